// File: design/rhsv_pkg.sv
package rhsv_pkg;

  localparam int HUE_FRAC_BITS_DEF = 6;
  localparam int IN_W  = 8;
  localparam int HUE_W = 15;
  localparam int SAT_W = 13;
  localparam int VAL_W = 7;

  // Data carried beside the dividers
  typedef struct packed {
    logic             grey;
    logic             neg;
    logic [VAL_W-1:0] val;
  } side_t;

endpackage

// File: design/rhsv_prep.sv
module rhsv_prep import rhsv_pkg::*; #(
  parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
  parameter int QW = 9 + HUE_FRAC_BITS,
  parameter int NW = 8 + QW
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [IN_W-1:0] red,
  input  logic [IN_W-1:0] green,
  input  logic [IN_W-1:0] blue,
  output logic            out_valid,
  output logic [IN_W-1:0] delta_q,
  output logic [IN_W-1:0] max_q,
  output logic [NW-1:0]   hue_num,
  output logic [NW-1:0]   sat_num,
  output side_t           side
);

  logic [IN_W-1:0] mx, mn, dl;
  logic signed [17:0] hn;
  logic [17:0] hmag;
  logic [14:0] vp;
  logic [15:0] vq;
  logic neg;

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    dl = mx - mn;
    if (mx == red) begin
      hn = 18'(signed'({1'b0, green})) - 18'(signed'({1'b0, blue}));
      hn = hn * 18'sd60;
    end else if (mx == green) begin
      hn = (18'(signed'({1'b0, blue})) - 18'(signed'({1'b0, red}))) * 18'sd60
           + 18'(signed'({1'b0, dl})) * 18'sd120;
    end else begin
      hn = (18'(signed'({1'b0, red})) - 18'(signed'({1'b0, green}))) * 18'sd60
           + 18'(signed'({1'b0, dl})) * 18'sd240;
    end
    neg  = hn[17];
    hmag = neg ? 18'(-hn) : 18'(hn);
    vp   = 15'(mx) * 15'd100;
    // exact divide by 255 for the 15-bit product
    vq   = (16'(vp) + 16'(vp >> 8) + 16'd1) >> 8;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    delta_q   <= dl;
    max_q     <= mx;
    hue_num   <= NW'(hmag) << HUE_FRAC_BITS;
    sat_num   <= (NW'(dl) * NW'(100)) << HUE_FRAC_BITS;
    side.grey <= (dl == '0);
    side.neg  <= neg;
    side.val  <= vq[VAL_W-1:0];
  end

endmodule

// File: design/rhsv_div_cell.sv
module rhsv_div_cell import rhsv_pkg::*; #(
  parameter int QW = 15
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [IN_W-1:0] h_div_in,
  input  logic [IN_W-1:0] s_div_in,
  input  logic [IN_W-1:0] h_rem_in,
  input  logic [IN_W-1:0] s_rem_in,
  input  logic [QW-1:0]   h_num_in,
  input  logic [QW-1:0]   s_num_in,
  input  logic [QW-1:0]   h_quo_in,
  input  logic [QW-1:0]   s_quo_in,
  input  side_t           side_in,
  output logic            out_valid,
  output logic [IN_W-1:0] h_div_out,
  output logic [IN_W-1:0] s_div_out,
  output logic [IN_W-1:0] h_rem_out,
  output logic [IN_W-1:0] s_rem_out,
  output logic [QW-1:0]   h_num_out,
  output logic [QW-1:0]   s_num_out,
  output logic [QW-1:0]   h_quo_out,
  output logic [QW-1:0]   s_quo_out,
  output side_t           side_out
);

  logic [IN_W+1:0] h_trial, s_trial;
  logic h_bit, s_bit;

  always_comb begin
    h_trial = {1'b0, h_rem_in, h_num_in[QW-1]} - {2'b00, h_div_in};
    s_trial = {1'b0, s_rem_in, s_num_in[QW-1]} - {2'b00, s_div_in};
    h_bit   = !h_trial[IN_W+1];
    s_bit   = !s_trial[IN_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    h_div_out <= h_div_in;
    s_div_out <= s_div_in;
    h_rem_out <= h_bit ? h_trial[IN_W-1:0] : {h_rem_in[IN_W-2:0], h_num_in[QW-1]};
    s_rem_out <= s_bit ? s_trial[IN_W-1:0] : {s_rem_in[IN_W-2:0], s_num_in[QW-1]};
    h_num_out <= h_num_in << 1;
    s_num_out <= s_num_in << 1;
    h_quo_out <= {h_quo_in[QW-2:0], h_bit};
    s_quo_out <= {s_quo_in[QW-2:0], s_bit};
    side_out  <= side_in;
  end

endmodule

// File: design/rgb_to_hsv_converter_top.sv
// RGB to HSV pixel converter.
// Input: drive red, green, blue and pulse start; an item is taken at every
// clock edge with start high and busy low. busy is always low, so one
// pixel may enter every cycle.
// Output: done is high for exactly one cycle with hue, saturation and value;
// the receiver cannot stall, so the results must be taken in that cycle.
// Stages: registered max/min and numerator setup, one divider cell per
// quotient bit (HUE_FRAC_BITS + 9 cells, each a restoring step for hue
// and saturation), and one output register. Throughput: one pixel per clock.
// Hue is degrees times 2^HUE_FRAC_BITS, saturation percent times
// 2^HUE_FRAC_BITS, value an integer percent. Grey pixels give hue and
// saturation 0.
// Reset clears the valid marks in the chain; items in flight are dropped.
module rgb_to_hsv_converter_top import rhsv_pkg::*; #(
  parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [IN_W-1:0]  red,
  input  logic [IN_W-1:0]  green,
  input  logic [IN_W-1:0]  blue,
  output logic             done,
  output logic [HUE_W-1:0] hue,
  output logic [SAT_W-1:0] saturation,
  output logic [VAL_W-1:0] value
);

  localparam int QW = 9 + HUE_FRAC_BITS;
  localparam int NW = 8 + QW;

  logic [IN_W-1:0] p_delta, p_max;
  logic [NW-1:0]   p_hnum, p_snum;
  logic            p_valid;
  side_t           p_side;

  logic            c_valid [QW+1];
  logic [IN_W-1:0] c_hdiv [QW+1];
  logic [IN_W-1:0] c_sdiv [QW+1];
  logic [IN_W-1:0] c_hrem [QW+1];
  logic [IN_W-1:0] c_srem [QW+1];
  logic [QW-1:0]   c_hnum [QW+1];
  logic [QW-1:0]   c_snum [QW+1];
  logic [QW-1:0]   c_hquo [QW+1];
  logic [QW-1:0]   c_squo [QW+1];
  side_t           c_side [QW+1];

  logic [31:0] hq, hres, sres;

  assign busy = 1'b0;

  rhsv_prep #(.HUE_FRAC_BITS(HUE_FRAC_BITS), .QW(QW), .NW(NW)) u_prep (
    .clk(clk), .rst(rst), .in_valid(start),
    .red(red), .green(green), .blue(blue),
    .out_valid(p_valid), .delta_q(p_delta), .max_q(p_max),
    .hue_num(p_hnum), .sat_num(p_snum), .side(p_side)
  );

  // quotient fits in QW bits, so the top bits start as the remainder
  assign c_valid[0] = p_valid;
  assign c_hdiv[0]  = p_delta;
  assign c_sdiv[0]  = p_max;
  assign c_hrem[0]  = p_hnum[NW-1:QW];
  assign c_srem[0]  = p_snum[NW-1:QW];
  assign c_hnum[0]  = p_hnum[QW-1:0];
  assign c_snum[0]  = p_snum[QW-1:0];
  assign c_hquo[0]  = '0;
  assign c_squo[0]  = '0;
  assign c_side[0]  = p_side;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    rhsv_div_cell #(.QW(QW)) u_cell (
      .clk(clk), .rst(rst), .in_valid(c_valid[i]),
      .h_div_in(c_hdiv[i]), .s_div_in(c_sdiv[i]),
      .h_rem_in(c_hrem[i]), .s_rem_in(c_srem[i]),
      .h_num_in(c_hnum[i]), .s_num_in(c_snum[i]),
      .h_quo_in(c_hquo[i]), .s_quo_in(c_squo[i]),
      .side_in(c_side[i]),
      .out_valid(c_valid[i+1]),
      .h_div_out(c_hdiv[i+1]), .s_div_out(c_sdiv[i+1]),
      .h_rem_out(c_hrem[i+1]), .s_rem_out(c_srem[i+1]),
      .h_num_out(c_hnum[i+1]), .s_num_out(c_snum[i+1]),
      .h_quo_out(c_hquo[i+1]), .s_quo_out(c_squo[i+1]),
      .side_out(c_side[i+1])
    );
  end

  always_comb begin
    hq = 32'(c_hquo[QW]);
    // wrap a negative red-sector hue; a zero quotient stays zero
    if (c_side[QW].neg && hq != '0) begin
      hres = (32'd360 << HUE_FRAC_BITS) - hq;
    end else begin
      hres = hq;
    end
    sres = 32'(c_squo[QW]);
    if (c_side[QW].grey) begin
      hres = '0;
      sres = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c_valid[QW];
    end
    hue        <= hres[HUE_W-1:0];
    saturation <= sres[SAT_W-1:0];
    value      <= c_side[QW].val;
  end

  assert property (@(posedge clk) disable iff (rst) done |-> value <= VAL_W'(100))
    else $error("value above 100");
  assert property (@(posedge clk) disable iff (rst)
    c_valid[QW] |-> hres < (32'd360 << HUE_FRAC_BITS))
    else $error("hue out of range");
  assert property (@(posedge clk) disable iff (rst)
    c_valid[QW] |-> sres <= (32'd100 << HUE_FRAC_BITS))
    else $error("saturation out of range");

endmodule

// File: dv/rgb_to_hsv_checker.sv
`timescale 1ns / 1ps
module rgb_to_hsv_checker import rhsv_pkg::*; #(
  parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic [IN_W-1:0]  red,
  input  logic [IN_W-1:0]  green,
  input  logic [IN_W-1:0]  blue,
  input  logic             done,
  input  logic [HUE_W-1:0] hue,
  input  logic [SAT_W-1:0] saturation,
  input  logic [VAL_W-1:0] value,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [HUE_W-1:0] h;
    logic [SAT_W-1:0] s;
    logic [VAL_W-1:0] v;
  } hsv_t;

  hsv_t hsv_q[$];

  function automatic hsv_t pixel_to_hsv(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
    longint r, g, b, mx, mn, d, h, s, v, one;
    hsv_t o;
    r = r8; g = g8; b = b8;
    one = longint'(1) << HUE_FRAC_BITS;
    mx = r; mn = r; h = 0; s = 0;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    if (d > 0) begin
      // SV division truncates toward zero, as needed here
      if (mx == r) h = (60 * (g - b) * one) / d;
      else if (mx == g) h = ((60 * (b - r) + 120 * d) * one) / d;
      else h = ((60 * (r - g) + 240 * d) * one) / d;
      if (h < 0) h += 360 * one;
      s = (d * 100 * one) / mx;
    end
    v = (mx * 100) / 255;
    o.h = h[HUE_W-1:0];
    o.s = s[SAT_W-1:0];
    o.v = v[VAL_W-1:0];
    return o;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch @%0t: %s", $time, msg);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = hsv_q.size();

  always @(posedge clk) begin
    hsv_t e;
    if (!rst) begin
      if (done) begin
        if (hsv_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result h=%0d s=%0d v=%0d",
                                    hue, saturation, value));
        end else begin
          e = hsv_q.pop_front();
          if (hue !== e.h)
            report_mismatch($sformatf("hue %0d, want %0d", hue, e.h));
          if (saturation !== e.s)
            report_mismatch($sformatf("saturation %0d, want %0d", saturation, e.s));
          if (value !== e.v)
            report_mismatch($sformatf("value %0d, want %0d", value, e.v));
        end
      end
      if (start && !busy) hsv_q.push_back(pixel_to_hsv(red, green, blue));
    end
  end

endmodule

// File: dv/rgb_to_hsv_converter_top_tb.sv
`timescale 1ns / 1ps
module rgb_to_hsv_converter_top_tb;
  import rhsv_pkg::*;

  logic clk, rst, start, busy, done;
  logic [IN_W-1:0] red, green, blue;
  logic [HUE_W-1:0] hue;
  logic [SAT_W-1:0] saturation;
  logic [VAL_W-1:0] value;
  int fail_count, pending, cycles;

  rgb_to_hsv_converter_top dut (.*);
  rgb_to_hsv_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Hold the pixel until it is taken, then drop start unless another follows
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit keep);
    red <= r; green <= g; blue <= b; start <= 1'b1;
    do @(posedge clk); while (busy);
    if (!keep) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    logic [7:0] p[3];
    int m;
    rst = 1; start = 0; red = 0; green = 0; blue = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // extremes, ties, grey, sectors, small negative red hue
    send_pixel(0, 0, 0, 0);
    send_pixel(255, 255, 255, 0);
    send_pixel(128, 128, 128, 0);
    send_pixel(255, 0, 0, 0);
    send_pixel(0, 255, 0, 0);
    send_pixel(0, 0, 255, 0);
    send_pixel(255, 255, 0, 0);
    send_pixel(0, 255, 255, 0);
    send_pixel(255, 0, 255, 0);
    send_pixel(255, 0, 1, 0);
    send_pixel(255, 254, 255, 1);
    send_pixel(200, 0, 1, 1);
    send_pixel(1, 0, 0, 1);
    send_pixel(0, 1, 1, 1);
    send_pixel(255, 128, 127, 1);
    send_pixel(170, 85, 85, 1);
    send_pixel(1, 2, 3, 0);
    for (int i = 0; i < 1600; i++) begin
      for (int k = 0; k < 3; k++) p[k] = $urandom_range(0, 255);
      case ($urandom_range(0, 7))
        0: begin m = $urandom_range(0, 2); p[(m + 1) % 3] = p[m]; end
        1: begin p[1] = p[0]; p[2] = p[0]; end
        2: p[$urandom_range(0, 2)] = p[$urandom_range(0, 2)] ^ 8'd1;
        default: ;
      endcase
      send_pixel(p[0], p[1], p[2], 1);
      if ($urandom_range(0, 2) == 0) random_gap();
    end
    start <= 0;
    while (pending > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// File: rgb_to_hsv_converter_top.f
design/rhsv_pkg.sv
design/rhsv_prep.sv
design/rhsv_div_cell.sv
design/rgb_to_hsv_converter_top.sv
dv/rgb_to_hsv_checker.sv
dv/rgb_to_hsv_converter_top_tb.sv
